// ===== hw/rtl/mamc_pkg.sv =====
// Shared codes, reset values and the step record for the motion alarm mode controller.
// Self-contained: no dependencies.
`default_nettype none

package mamc_pkg;

   // Alarm modes
   localparam logic [1:0] MODE_IDLE   = 2'd0;
   localparam logic [1:0] MODE_PANIC  = 2'd1;
   localparam logic [1:0] MODE_SILENT = 2'd2;
   localparam logic [1:0] MODE_PAUSED = 2'd3;

   // Item kinds on the request channel
   localparam logic [2:0] KIND_TICK   = 3'd0;
   localparam logic [2:0] KIND_CLICK  = 3'd1;
   localparam logic [2:0] KIND_HOLD   = 3'd2;
   localparam logic [2:0] KIND_ADD    = 3'd3;
   localparam logic [2:0] KIND_RESET  = 3'd4;
   localparam logic [2:0] KIND_TEST   = 3'd5;

   // Buzzer commands
   localparam logic [1:0] BUZZ_NONE  = 2'd0;
   localparam logic [1:0] BUZZ_START = 2'd1;
   localparam logic [1:0] BUZZ_STOP  = 2'd2;

   // LED commands
   localparam logic [2:0] LED_NONE      = 3'd0;
   localparam logic [2:0] LED_OFF       = 3'd1;
   localparam logic [2:0] LED_PANIC     = 3'd2;
   localparam logic [2:0] LED_COOL      = 3'd3;
   localparam logic [2:0] LED_BLINK     = 3'd4;
   localparam logic [2:0] LED_COUNTDOWN = 3'd5;

   // Configuration register indexes
   localparam logic [1:0] CSR_BUZZ_HOLD    = 2'd0;
   localparam logic [1:0] CSR_SILENCE_UNIT = 2'd1;
   localparam logic [1:0] CSR_IDLE_FLASH   = 2'd2;
   localparam logic [1:0] CSR_PANIC_COLOUR = 2'd3;

   localparam logic [31:0] BUZZ_HOLD_RESET    = 32'd5000;
   localparam logic [31:0] SILENCE_UNIT_RESET = 32'd60000;
   localparam logic [31:0] IDLE_FLASH_RESET   = 32'd5000;
   localparam logic [15:0] PANIC_COLOUR_RESET = 16'd500;

   localparam logic [7:0] COLOUR_FULL      = 8'd255;
   localparam logic [7:0] COLOUR_HEARTBEAT = 8'd64;
   localparam logic [7:0] COLOUR_COOL      = 8'd3;
   localparam logic [7:0] LEVEL_MAX        = 8'd255;

   localparam int DIV_STEPS = 32;

   // Working record of one step: state after the step plus the result flags
   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] last;
      logic [7:0]  level;
      logic [31:0] stime;
      logic        modechg;
      logic        silchg;
      logic [1:0]  buzz;
      logic [2:0]  led;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic        cval;
   } step_type;

endpackage

`default_nettype wire

// ===== hw/rtl/motion_alarm_mode_controller_top.sv =====
// Motion alarm mode controller: mode sequencer with a shared serial divider.
// Depends on mamc_pkg.
`default_nettype none

// One item in, one item out. Clicks, holds, silence events, alarm tests and ticks in idle
// or paused mode pass through S_MUL, S_EVAL and S_DONE before the result is registered.
// Ticks that end in panic or silent mode with a nonzero divisor also divide through a
// 32-step restoring divider (one quotient bit per cycle) in S_DIV, then S_FIN. S_DONE
// holds the result while the output register is full and not taken. The block takes
// no new item while one is at work, but it does take one while the previous result still
// waits in the output register.
// Configuration writes are always taken (csr_ready is tied high) and belong to idle time.
module motion_alarm_mode_controller_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_mode,
   input  wire logic [31:0] req_now_ms,
   input  wire logic        req_motion,
   input  wire logic        req_power,
   input  wire logic [7:0]  req_click_count,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_mode_now,
   output logic             rsp_mode_changed,
   output logic             rsp_silence_changed,
   output logic [7:0]       rsp_level_of_silence,
   output logic [1:0]       rsp_buzzer_cmd,
   output logic [2:0]       rsp_led_cmd,
   output logic [7:0]       rsp_led_red,
   output logic [7:0]       rsp_led_green,
   output logic [7:0]       rsp_led_blue,
   output logic             rsp_colour_valid,
   output logic [7:0]       rsp_countdown_level,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_data
);

   localparam int CNT_W = $clog2(mamc_pkg::DIV_STEPS);

   typedef enum logic [2:0] {S_IDLE, S_MUL, S_EVAL, S_DIV, S_FIN, S_DONE} state_type;

   state_type state_ff;

   // latched item
   logic [2:0]  kind_ff;
   logic [31:0] now_ff;
   logic        motion_ff;
   logic        power_ff;
   logic [7:0]  count_ff;

   // alarm state
   logic [1:0]  mode_ff;
   logic [31:0] last_ff;
   logic [7:0]  level_ff;
   logic [31:0] stime_ff;

   // configuration
   logic [31:0] buzz_hold_ff;
   logic [31:0] unit_ff;
   logic [31:0] flash_ff;
   logic [15:0] pcol_ff;

   logic [39:0] prod_ff;
   mamc_pkg::step_type res_ff;
   logic [7:0]  cdl_ff;
   mamc_pkg::step_type rsp_ff;
   logic [7:0]  rsp_cdl_ff;
   logic        rsp_valid_ff;

   // divider
   logic [31:0]      rem_ff;
   logic [31:0]      quo_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             div_panic_ff;

   function automatic mamc_pkg::step_type go_mode(input mamc_pkg::step_type s,
                                                  input logic [1:0] nxt,
                                                  input logic [31:0] now);
      mamc_pkg::step_type r;
      r = s;
      if (nxt != s.mode) begin
         if (s.mode == mamc_pkg::MODE_PANIC) begin
            r.buzz = mamc_pkg::BUZZ_STOP;
         end else if (s.mode == mamc_pkg::MODE_SILENT) begin
            r.stime  = '0;
            r.level  = '0;
            r.silchg = 1'b1;
         end
         if (nxt == mamc_pkg::MODE_PANIC) begin
            r.buzz = mamc_pkg::BUZZ_START;
            r.led  = mamc_pkg::LED_PANIC;
         end else if (nxt == mamc_pkg::MODE_SILENT) begin
            r.red   = '0;
            r.green = mamc_pkg::COLOUR_COOL;
            r.blue  = '0;
            r.cval  = 1'b1;
            r.led   = mamc_pkg::LED_COOL;
         end else begin
            r.led = mamc_pkg::LED_OFF;
         end
         r.mode    = nxt;
         r.last    = now;
         r.modechg = 1'b1;
      end
      return r;
   endfunction

   // ---------------- step evaluation ----------------
   logic [7:0]  level_inc;
   logic [7:0]  mul_a;
   logic [31:0] sat_prod;
   logic [31:0] delta1;
   logic [31:0] delta2;
   mamc_pkg::step_type st;
   logic        need_div;
   logic        div_panic;
   logic [31:0] div_dvd;
   logic [7:0]  cdl;

   assign level_inc = (level_ff == mamc_pkg::LEVEL_MAX) ? level_ff : level_ff + 8'd1;
   assign mul_a     = (kind_ff == mamc_pkg::KIND_CLICK) ? count_ff : level_inc;
   assign sat_prod  = (|prod_ff[39:32]) ? '1 : prod_ff[31:0];

   always_comb begin
      st         = '0;
      st.mode    = mode_ff;
      st.last    = last_ff;
      st.level   = level_ff;
      st.stime   = stime_ff;
      st.buzz    = mamc_pkg::BUZZ_NONE;
      st.led     = mamc_pkg::LED_NONE;
      need_div   = 1'b0;
      div_panic  = 1'b0;
      div_dvd    = '0;
      cdl        = '0;
      delta1     = '0;
      delta2     = '0;
      case (kind_ff)
         mamc_pkg::KIND_TICK: begin
            if (!power_ff) begin
               st = go_mode(st, mamc_pkg::MODE_PAUSED, now_ff);
            end else if (st.mode == mamc_pkg::MODE_PAUSED) begin
               st = go_mode(st, mamc_pkg::MODE_IDLE, now_ff);
            end
            delta1 = now_ff - st.last;
            case (st.mode)
               mamc_pkg::MODE_IDLE: begin
                  if (motion_ff) st = go_mode(st, mamc_pkg::MODE_PANIC, now_ff);
               end
               mamc_pkg::MODE_PANIC: begin
                  if (delta1 >= buzz_hold_ff && !motion_ff)
                     st = go_mode(st, mamc_pkg::MODE_IDLE, now_ff);
               end
               mamc_pkg::MODE_SILENT: begin
                  if (delta1 >= st.stime) st = go_mode(st, mamc_pkg::MODE_IDLE, now_ff);
               end
               default: ;
            endcase
            delta2 = now_ff - st.last;
            case (st.mode)
               mamc_pkg::MODE_IDLE: begin
                  if (delta2 >= flash_ff) begin
                     st.last  = now_ff;
                     st.red   = mamc_pkg::COLOUR_HEARTBEAT;
                     st.green = '0;
                     st.blue  = '0;
                     st.cval  = 1'b1;
                     st.led   = mamc_pkg::LED_BLINK;
                  end
               end
               mamc_pkg::MODE_PANIC: begin
                  if (pcol_ff == '0) begin
                     // zero period: quotient reads as all ones, so red
                     st.red   = mamc_pkg::COLOUR_FULL;
                     st.green = '0;
                     st.blue  = '0;
                     st.cval  = 1'b1;
                  end else begin
                     need_div  = 1'b1;
                     div_panic = 1'b1;
                     div_dvd   = delta2;
                  end
               end
               mamc_pkg::MODE_SILENT: begin
                  st.led = mamc_pkg::LED_COUNTDOWN;
                  if (unit_ff == '0) begin
                     cdl = mamc_pkg::LEVEL_MAX;
                  end else begin
                     need_div = 1'b1;
                     div_dvd  = st.stime - delta2 - 32'd1;
                  end
               end
               default: ;
            endcase
         end
         mamc_pkg::KIND_CLICK: begin
            if (st.mode != mamc_pkg::MODE_PAUSED && count_ff > st.level) begin
               st.stime  = sat_prod;
               st.level  = count_ff;
               st        = go_mode(st, mamc_pkg::MODE_SILENT, now_ff);
               st.silchg = 1'b1;
            end
         end
         mamc_pkg::KIND_HOLD: begin
            if (st.mode == mamc_pkg::MODE_SILENT) st = go_mode(st, mamc_pkg::MODE_IDLE, now_ff);
         end
         mamc_pkg::KIND_ADD: begin
            if (st.mode != mamc_pkg::MODE_PAUSED) begin
               // going to silent never clears, so the precomputed product still applies
               st        = go_mode(st, mamc_pkg::MODE_SILENT, now_ff);
               st.level  = level_inc;
               st.stime  = sat_prod;
               st.silchg = 1'b1;
            end
         end
         mamc_pkg::KIND_RESET: begin
            if (st.mode != mamc_pkg::MODE_PAUSED) st = go_mode(st, mamc_pkg::MODE_IDLE, now_ff);
         end
         mamc_pkg::KIND_TEST: begin
            st = go_mode(st, mamc_pkg::MODE_PANIC, now_ff);
         end
         default: ;
      endcase
   end

   // ---------------- shared restoring divider ----------------
   logic [31:0] divisor;
   logic [32:0] trial;
   logic [32:0] diff;
   logic        qbit;

   assign divisor = div_panic_ff ? {16'd0, pcol_ff} : unit_ff;
   assign trial   = {rem_ff, quo_ff[31]};
   assign diff    = trial - {1'b0, divisor};
   assign qbit    = (trial >= {1'b0, divisor});

   // ---------------- sequencer ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= mamc_pkg::MODE_IDLE;
         last_ff      <= '0;
         level_ff     <= '0;
         stime_ff     <= '0;
         buzz_hold_ff <= mamc_pkg::BUZZ_HOLD_RESET;
         unit_ff      <= mamc_pkg::SILENCE_UNIT_RESET;
         flash_ff     <= mamc_pkg::IDLE_FLASH_RESET;
         pcol_ff      <= mamc_pkg::PANIC_COLOUR_RESET;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               mamc_pkg::CSR_BUZZ_HOLD:    buzz_hold_ff <= csr_data;
               mamc_pkg::CSR_SILENCE_UNIT: unit_ff      <= csr_data;
               mamc_pkg::CSR_IDLE_FLASH:   flash_ff     <= csr_data;
               mamc_pkg::CSR_PANIC_COLOUR: pcol_ff      <= csr_data[15:0];
               default: ;
            endcase
         end

         // S_DONE reloads the output register itself
         if (rsp_valid_ff && rsp_ready && state_ff != S_DONE) rsp_valid_ff <= 1'b0;

         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  kind_ff   <= req_mode;
                  now_ff    <= req_now_ms;
                  motion_ff <= req_motion;
                  power_ff  <= req_power;
                  count_ff  <= req_click_count;
                  state_ff  <= S_MUL;
               end
            end
            S_MUL: begin
               prod_ff  <= {32'd0, mul_a} * {8'd0, unit_ff};
               state_ff <= S_EVAL;
            end
            S_EVAL: begin
               mode_ff  <= st.mode;
               last_ff  <= st.last;
               level_ff <= st.level;
               stime_ff <= st.stime;
               res_ff   <= st;
               cdl_ff   <= cdl;
               if (need_div) begin
                  quo_ff       <= div_dvd;
                  rem_ff       <= '0;
                  cnt_ff       <= '0;
                  div_panic_ff <= div_panic;
                  state_ff     <= S_DIV;
               end else begin
                  state_ff <= S_DONE;
               end
            end
            S_DIV: begin
               rem_ff <= qbit ? diff[31:0] : trial[31:0];
               quo_ff <= {quo_ff[30:0], qbit};
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CNT_W'(mamc_pkg::DIV_STEPS - 1)) state_ff <= S_FIN;
            end
            S_FIN: begin
               if (div_panic_ff) begin
                  // odd quotient: red, even: blue
                  res_ff.red   <= quo_ff[0] ? mamc_pkg::COLOUR_FULL : 8'd0;
                  res_ff.green <= '0;
                  res_ff.blue  <= quo_ff[0] ? 8'd0 : mamc_pkg::COLOUR_FULL;
                  res_ff.cval  <= 1'b1;
               end else begin
                  cdl_ff <= (quo_ff >= 32'(mamc_pkg::LEVEL_MAX)) ? mamc_pkg::LEVEL_MAX
                                                                : quo_ff[7:0] + 8'd1;
               end
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_ff       <= res_ff;
                  rsp_cdl_ff   <= cdl_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready            = (state_ff == S_IDLE);
   assign csr_ready            = 1'b1;
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_mode_now         = rsp_ff.mode;
   assign rsp_mode_changed     = rsp_ff.modechg;
   assign rsp_silence_changed  = rsp_ff.silchg;
   assign rsp_level_of_silence = rsp_ff.level;
   assign rsp_buzzer_cmd       = rsp_ff.buzz;
   assign rsp_led_cmd          = rsp_ff.led;
   assign rsp_led_red          = rsp_ff.red;
   assign rsp_led_green        = rsp_ff.green;
   assign rsp_led_blue         = rsp_ff.blue;
   assign rsp_colour_valid     = rsp_ff.cval;
   assign rsp_countdown_level  = rsp_cdl_ff;

   // ---------------- assertions ----------------
   // silence is only held in silent mode
   a_silence_only_silent: assert property (@(posedge clock) disable iff (reset)
      (mode_ff != mamc_pkg::MODE_SILENT) |-> (level_ff == '0 && stime_ff == '0))
      else $error("silence held outside silent mode");

   a_countdown_silent: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_countdown_level != '0) |-> (rsp_mode_now == mamc_pkg::MODE_SILENT))
      else $error("countdown level outside silent mode");

   a_start_in_panic: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_buzzer_cmd == mamc_pkg::BUZZ_START) |->
         (rsp_mode_now == mamc_pkg::MODE_PANIC && rsp_mode_changed))
      else $error("melody start without entering panic");

   a_buzz_needs_change: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_mode_changed) |-> (rsp_buzzer_cmd == mamc_pkg::BUZZ_NONE))
      else $error("buzzer command without mode change");

endmodule

`default_nettype wire
